/* rtl/bhist_pkg.sv */
// Shared types and codes for the bounded record history table.
`timescale 1ns / 1ps

package bhist_pkg;

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_FIND = 2'd1,
    ACT_DEL  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_e;

  typedef struct packed {
    action_e     action;
    logic [31:0] time_secs;
    logic [10:0] temp_tenths_f;
    logic [8:0]  pulse_bpm;
    logic [6:0]  resp_bpm;
    logic [8:0]  bp_diastolic;
    logic [8:0]  bp_systolic;
    logic [9:0]  glucose_mgdl;
    logic [2:0]  slot_index;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  found_index;
    logic [3:0]  entry_count;
    logic        evicted;
  } out_t;

  // one stored record
  typedef struct packed {
    logic [31:0] rec_time;
    logic [10:0] rec_temp;
    logic [8:0]  rec_pulse;
    logic [6:0]  rec_resp;
    logic [8:0]  rec_dia;
    logic [8:0]  rec_sys;
    logic [9:0]  rec_gluc;
  } rec_t;

endpackage

/* rtl/bhist_mem.sv */
// Record store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module bhist_mem #(
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  bhist_pkg::rec_t          wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output bhist_pkg::rec_t          rdata_o
);

  bhist_pkg::rec_t mem_q [Depth];
  bhist_pkg::rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bounded_record_history_table.sv */
// Top level: ring-addressed record history with find and compacting delete.
//
//  channel | signals                          | direction | payload
//  --------+----------------------------------+-----------+------------------
//  in      | in_valid_i / in_ready_o          | to block  | bhist_pkg::in_t
//  out     | out_valid_o / out_ready_i        | from block| bhist_pkg::out_t
//
// Add, an empty find, a bad delete, a delete of the newest entry and the unused
// code finish in the transfer cycle. Find reads and compares one entry at a time
// (read state, then compare state) through the single memory read port.
// Delete moves each later entry down, a read then a write per moved entry.
// Reset empties the table at once (count and ring head cleared); no sweep.
// One item is in work at a time; a finished result sits in the output
// register and a new item is taken in the cycle that result is transferred.
`timescale 1ns / 1ps

module bounded_record_history_table #(
  parameter int unsigned HISTORY_DEPTH = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bhist_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bhist_pkg::out_t out_data_o
);

  localparam int unsigned IW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned PW = (CW > 3) ? CW : 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CMP,
    S_DEL_RD,
    S_DEL_WR
  } state_e;

  state_e           state_q, state_d;
  logic [IW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [31:0]      key_q, key_d;
  logic             out_valid_q, out_valid_d;
  bhist_pkg::out_t  out_q, out_d;

  logic             mem_we, mem_re;
  logic [IW-1:0]    mem_waddr, mem_raddr;
  bhist_pkg::rec_t  mem_wdata, mem_rdata;
  bhist_pkg::rec_t  new_rec;
  logic             in_xfer, full;

  // logical position -> physical slot, sum stays below twice the depth
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] l);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(l);
    if (s >= (CW+1)'(HISTORY_DEPTH)) begin
      s = s - (CW+1)'(HISTORY_DEPTH);
    end
    return IW'(s);
  endfunction

  function automatic logic [IW-1:0] inc_head(input logic [IW-1:0] h);
    return (h == IW'(HISTORY_DEPTH - 1)) ? '0 : IW'(h + IW'(1));
  endfunction

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign full       = (count_q == CW'(HISTORY_DEPTH));

  assign new_rec = '{
    rec_time:  in_data_i.time_secs,
    rec_temp:  in_data_i.temp_tenths_f,
    rec_pulse: in_data_i.pulse_bpm,
    rec_resp:  in_data_i.resp_bpm,
    rec_dia:   in_data_i.bp_diastolic,
    rec_sys:   in_data_i.bp_systolic,
    rec_gluc:  in_data_i.glucose_mgdl
  };

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = phys(head_q, count_q);
    mem_wdata   = new_rec;
    mem_re      = 1'b0;
    mem_raddr   = phys(head_q, idx_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          out_d = '{status: bhist_pkg::ST_OK, found_index: 3'd0,
                    entry_count: 4'(count_q), evicted: 1'b0};
          case (in_data_i.action)
            bhist_pkg::ACT_ADD: begin
              mem_we      = 1'b1;
              out_valid_d = 1'b1;
              if (full) begin
                // oldest slot is overwritten and the ring start moves on
                mem_waddr     = head_q;
                head_d        = inc_head(head_q);
                out_d.evicted = 1'b1;
              end else begin
                count_d = CW'(count_q + CW'(1));
              end
              out_d.entry_count = 4'(count_d);
            end
            bhist_pkg::ACT_FIND: begin
              key_d = in_data_i.time_secs;
              idx_d = '0;
              if (count_q == '0) begin
                out_d.status = bhist_pkg::ST_NOT_FOUND;
                out_valid_d  = 1'b1;
              end else begin
                state_d = S_FIND_RD;
              end
            end
            bhist_pkg::ACT_DEL: begin
              idx_d = CW'(in_data_i.slot_index);
              if (PW'(in_data_i.slot_index) >= PW'(count_q)) begin
                out_d.status = bhist_pkg::ST_BAD_INDEX;
                out_valid_d  = 1'b1;
              end else if (PW'(in_data_i.slot_index) + PW'(1) == PW'(count_q)) begin
                count_d           = CW'(count_q - CW'(1));
                out_d.entry_count = 4'(count_d);
                out_valid_d       = 1'b1;
              end else begin
                state_d = S_DEL_RD;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_FIND_RD: begin
        mem_re  = 1'b1;
        state_d = S_FIND_CMP;
      end
      S_FIND_CMP: begin
        if (mem_rdata.rec_time == key_q) begin
          out_d.found_index = 3'(idx_q);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end else if (CW'(idx_q + CW'(1)) == count_q) begin
          out_d.status = bhist_pkg::ST_NOT_FOUND;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else begin
          idx_d   = CW'(idx_q + CW'(1));
          state_d = S_FIND_RD;
        end
      end
      S_DEL_RD: begin
        mem_re    = 1'b1;
        mem_raddr = phys(head_q, CW'(idx_q + CW'(1)));
        state_d   = S_DEL_WR;
      end
      S_DEL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = phys(head_q, idx_q);
        mem_wdata = mem_rdata;
        if (CW'(idx_q + CW'(2)) < count_q) begin
          idx_d   = CW'(idx_q + CW'(1));
          state_d = S_DEL_RD;
        end else begin
          count_d           = CW'(count_q - CW'(1));
          out_d.entry_count = 4'(count_d);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      key_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      key_q       <= key_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  bhist_mem #(
    .Depth (HISTORY_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(HISTORY_DEPTH))
    else $error("entry count above depth");

  a_add_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_data_i.action == bhist_pkg::ACT_ADD && !full)
    |=> count_q == CW'($past(count_q) + CW'(1)))
    else $error("add to non-full table did not grow count");

  a_find_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIND_RD || state_q == S_FIND_CMP) |-> !mem_we)
    else $error("memory written during find");

  a_del_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEL_RD || state_q == S_DEL_WR)
    |-> ((CW+1)'(idx_q) + (CW+1)'(1) < (CW+1)'(count_q)))
    else $error("compaction beyond last valid entry");

  a_evict_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.evicted) |-> full)
    else $error("eviction flagged on a table that is not full");

endmodule
